FILE: sv/watering_pump_controller_top_macros.svh
// assertion macros for the watering pump controller
`ifndef WATERING_PUMP_CONTROLLER_TOP_MACROS_SVH
`define WATERING_PUMP_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define WPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WPC_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPC_ASSERT(lbl, clk, rst, prop, msg)
`define WPC_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/wpc_pkg.sv
`default_nettype none
package wpc_pkg;

   localparam int unsigned ThresholdWidth = 7;
   localparam int unsigned RegWidth       = 16;
   localparam int unsigned TimeWidth      = 32;

   localparam logic [TimeWidth-1:0] MS_PER_MINUTE = 32'd60000;
   localparam logic [TimeWidth-1:0] MS_PER_SECOND = 32'd1000;

   localparam logic [ThresholdWidth-1:0] THRESHOLD_RESET = 7'd40;
   localparam logic [TimeWidth-1:0] MAX_PUMP_MS_RESET = 32'd30 * MS_PER_SECOND;
   localparam logic [TimeWidth-1:0] COOLDOWN_MS_RESET = 32'd60 * MS_PER_MINUTE;
   localparam logic [TimeWidth-1:0] RECHECK_MS_RESET  = 32'd10 * MS_PER_SECOND;

   typedef enum logic [1:0] {
      REG_MOISTURE_THRESHOLD = 2'd0,
      REG_MAX_PUMP_SECONDS   = 2'd1,
      REG_COOLDOWN_MINUTES   = 2'd2,
      REG_RECHECK_SECONDS    = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [ThresholdWidth-1:0] threshold;
      logic [TimeWidth-1:0]      max_pump_ms;
      logic [TimeWidth-1:0]      cooldown_ms;
      logic [TimeWidth-1:0]      recheck_ms;
   } cfg_type;

endpackage
`default_nettype wire

FILE: sv/wpc_csr.sv
`default_nettype none
module wpc_csr
   import wpc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [RegWidth-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [TimeWidth-1:0] wdata_ext;

   assign wdata_ext = TimeWidth'(csr_wdata);

   // limits are kept already scaled to milliseconds
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx_type'(csr_index))
            REG_MOISTURE_THRESHOLD: cfg_in.threshold   = csr_wdata[ThresholdWidth-1:0];
            REG_MAX_PUMP_SECONDS:   cfg_in.max_pump_ms = wdata_ext * MS_PER_SECOND;
            REG_COOLDOWN_MINUTES:   cfg_in.cooldown_ms = wdata_ext * MS_PER_MINUTE;
            REG_RECHECK_SECONDS:    cfg_in.recheck_ms  = wdata_ext * MS_PER_SECOND;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= THRESHOLD_RESET;
         cfg_ff.max_pump_ms <= MAX_PUMP_MS_RESET;
         cfg_ff.cooldown_ms <= COOLDOWN_MS_RESET;
         cfg_ff.recheck_ms  <= RECHECK_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: sv/wpc_core.sv
`default_nettype none
`include "watering_pump_controller_top_macros.svh"
module wpc_core
   import wpc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic [TimeWidth-1:0]      now_ms,
   input  wire logic                      light_on,
   input  wire logic [ThresholdWidth-1:0] soil_percent,
   input  cfg_type                        cfg,
   output logic                           pump_next
);

   logic                 pumping_ff, pumping_in;
   logic                 has_run_ff, has_run_in;
   logic [TimeWidth-1:0] cycle_start_ff, cycle_start_in;
   logic [TimeWidth-1:0] last_check_ff, last_check_in;
   logic [TimeWidth-1:0] last_stop_ff, last_stop_in;

   logic [TimeWidth-1:0] since_stop;
   logic [TimeWidth-1:0] since_start;
   logic [TimeWidth-1:0] since_check;
   logic                 cool;
   logic                 soil_low;

   assign since_stop  = now_ms - last_stop_ff;
   assign since_start = now_ms - cycle_start_ff;
   assign since_check = now_ms - last_check_ff;
   assign cool        = !has_run_ff || (since_stop >= cfg.cooldown_ms);
   assign soil_low    = soil_percent < cfg.threshold;

   always_comb begin
      pumping_in     = pumping_ff;
      has_run_in     = has_run_ff;
      cycle_start_in = cycle_start_ff;
      last_check_in  = last_check_ff;
      last_stop_in   = last_stop_ff;
      if (advance) begin
         if (!pumping_ff) begin
            if (light_on && soil_low && cool) begin
               pumping_in     = 1'b1;
               cycle_start_in = now_ms;
               last_check_in  = now_ms;
            end
         end else if (!light_on || (since_start >= cfg.max_pump_ms)) begin
            pumping_in   = 1'b0;
            last_stop_in = now_ms;
            has_run_in   = 1'b1;
         end else if (since_check >= cfg.recheck_ms) begin
            last_check_in = now_ms;
            if (!soil_low) begin
               pumping_in   = 1'b0;
               last_stop_in = now_ms;
               has_run_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pumping_ff     <= 1'b0;
         has_run_ff     <= 1'b0;
         cycle_start_ff <= '0;
         last_check_ff  <= '0;
         last_stop_ff   <= '0;
      end else begin
         pumping_ff     <= pumping_in;
         has_run_ff     <= has_run_in;
         cycle_start_ff <= cycle_start_in;
         last_check_ff  <= last_check_in;
         last_stop_ff   <= last_stop_in;
      end
   end

   assign pump_next = pumping_in;

   // light off always ends a running cycle and records the stop
   `WPC_ASSERT(a_light_off_stops, clock, reset, (advance && pumping_ff && !light_on) |=> (!pumping_ff && has_run_ff && last_stop_ff == $past(now_ms)), "light off did not stop the pump")
   // state only moves with a transaction
   `WPC_ASSERT(a_hold_when_idle, clock, reset, !advance |=> ($stable(pumping_ff) && $stable(last_check_ff) && $stable(last_stop_ff)), "state changed without a transaction")
   // a fresh start aligns the check timer with the start time
   `WPC_ASSERT(a_start_aligns, clock, reset, (advance && !pumping_ff && pumping_in) |=> (last_check_ff == cycle_start_ff), "start did not align check timer")

endmodule
`default_nettype wire

FILE: sv/watering_pump_controller_top.sv
// an accepted request is held in the input register, then in the result register, where rsp_valid rises
// throughput: one transaction per cycle while rsp_stall is low, set by the single input and result registers
// rsp_stall holds the result register, and the input register then holds one more
// reset (synchronous, active high) clears the pump state and loads default limits
`default_nettype none
`include "watering_pump_controller_top_macros.svh"
module watering_pump_controller_top
   import wpc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [TimeWidth-1:0]      req_now_ms,
   input  wire logic                      req_light_on,
   input  wire logic [ThresholdWidth-1:0] req_soil_percent,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_pump_drive,
   input  wire logic                      csr_write,
   input  wire logic [1:0]                csr_index,
   input  wire logic [RegWidth-1:0]       csr_wdata
);

   cfg_type cfg;

   logic                      in_valid_ff, in_valid_in;
   logic [TimeWidth-1:0]      in_now_ff;
   logic                      in_light_ff;
   logic [ThresholdWidth-1:0] in_soil_ff;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_drive_ff;
   logic                      advance;
   logic                      req_take;
   logic                      pump_next;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   wpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wpc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .now_ms       (in_now_ff),
      .light_on     (in_light_ff),
      .soil_percent (in_soil_ff),
      .cfg          (cfg),
      .pump_next    (pump_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_now_ff   <= req_now_ms;
         in_light_ff <= req_light_on;
         in_soil_ff  <= req_soil_percent;
      end
      if (advance) begin
         out_drive_ff <= pump_next;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pump_drive = out_drive_ff;

   // a transaction held in the input register is never dropped
   `WPC_ASSERT(a_input_kept, clock, reset, (in_valid_ff && !advance) |=> in_valid_ff, "pending transaction lost")
   // every move out of the input register produces a result
   `WPC_ASSERT(a_advance_result, clock, reset, advance |=> out_valid_ff, "transaction did not produce a result")
   // no new transaction is taken while both registers are full and stalled
   `WPC_ASSERT_NORST(a_full_stall, clock, (!reset && in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall, "accepted while full")

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb
   import wpc_pkg::*;
();

   localparam int PREDICT = -1;

   typedef enum logic {ROW_UPDATE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0]  now;
      logic         light;
      logic [6:0]   soil;
      int           want_drive;
      reg_idx_type  idx;
      logic [15:0]  value;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_now_ms = '0;
   logic        req_light_on = 1'b0;
   logic [6:0]  req_soil_percent = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_pump_drive;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // predictor copy of limits and pump state
   logic [6:0]  thr_cfg = 7'd40;
   logic [15:0] max_pump_s = 16'd30;
   logic [15:0] cooldown_min = 16'd60;
   logic [15:0] recheck_s = 16'd10;
   logic        pump_on = 1'b0;
   logic [31:0] cycle_start_ms = '0;
   logic [31:0] last_check_ms = '0;
   logic [31:0] last_stop_ms = '0;
   logic        ran_once = 1'b0;

   logic         pump_expected[$];
   stim_row_type stim_rows[$];
   logic [31:0]  wall_ms = '0;
   int           idle_pct = 0;
   int           stall_pct = 0;
   int           mismatches = 0;

   watering_pump_controller_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_now_ms(req_now_ms),
      .req_light_on(req_light_on),
      .req_soil_percent(req_soil_percent),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pump_drive(rsp_pump_drive),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic pump_next(input logic [31:0] now, input logic light,
                                      input logic [6:0] soil);
      logic [31:0] cool_ms;
      logic [31:0] max_ms;
      logic [31:0] chk_ms;
      logic [31:0] since_stop;
      logic [31:0] since_start;
      logic [31:0] since_check;
      cool_ms = cooldown_min * MS_PER_MINUTE;
      max_ms = max_pump_s * MS_PER_SECOND;
      chk_ms = recheck_s * MS_PER_SECOND;
      since_stop = now - last_stop_ms;
      since_start = now - cycle_start_ms;
      since_check = now - last_check_ms;
      if (!pump_on) begin
         if (light && soil < thr_cfg && (!ran_once || since_stop >= cool_ms)) begin
            pump_on = 1'b1;
            cycle_start_ms = now;
            last_check_ms = now;
         end
      end else if (!light || since_start >= max_ms) begin
         pump_on = 1'b0;
         last_stop_ms = now;
         ran_once = 1'b1;
      end else if (since_check >= chk_ms) begin
         last_check_ms = now;
         if (soil >= thr_cfg) begin
            pump_on = 1'b0;
            last_stop_ms = now;
            ran_once = 1'b1;
         end
      end
      return pump_on;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic void add_update(input logic [31:0] now, input logic light,
                                      input logic [6:0] soil, input int want);
      stim_row_type r;
      r.kind = ROW_UPDATE;
      r.now = now;
      r.light = light;
      r.soil = soil;
      r.want_drive = want;
      r.idx = REG_MOISTURE_THRESHOLD;
      r.value = '0;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_csr(input reg_idx_type idx, input logic [15:0] value);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.now = '0;
      r.light = 1'b0;
      r.soil = '0;
      r.want_drive = PREDICT;
      r.idx = idx;
      r.value = value;
      stim_rows.push_back(r);
   endfunction

   task automatic send_update(input logic [31:0] now, input logic light,
                              input logic [6:0] soil, input int want);
      logic predicted;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_light_on <= light;
      req_soil_percent <= soil;
      do @(posedge clock); while (req_stall);
      predicted = pump_next(now, light, soil);
      if (want == PREDICT) begin
         pump_expected.push_back(predicted);
      end else begin
         pump_expected.push_back(want[0]);
      end
   endtask

   task automatic write_limit(input reg_idx_type idx, input logic [15:0] value);
      req_valid <= 1'b0;
      while (pump_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_MOISTURE_THRESHOLD: thr_cfg = value[6:0];
         REG_MAX_PUMP_SECONDS:   max_pump_s = value;
         REG_COOLDOWN_MINUTES:   cooldown_min = value;
         REG_RECHECK_SECONDS:    recheck_s = value;
      endcase
   endtask

   task automatic load_limits(input logic [15:0] thr, input logic [15:0] max_s,
                              input logic [15:0] cool_m, input logic [15:0] chk_s);
      write_limit(REG_MOISTURE_THRESHOLD, thr);
      write_limit(REG_MAX_PUMP_SECONDS, max_s);
      write_limit(REG_COOLDOWN_MINUTES, cool_m);
      write_limit(REG_RECHECK_SECONDS, chk_s);
   endtask

   task automatic random_update();
      int          pick;
      int          s;
      logic        light;
      logic [6:0]  soil;
      pick = $urandom_range(99);
      if (pick < 4) begin
         wall_ms = $urandom;
      end else if (pick < 34) begin
         wall_ms = wall_ms + 500 * $urandom_range(0, 6);
      end else if (pick < 74) begin
         wall_ms = wall_ms + $urandom_range(0, 3000);
      end else if (pick < 94) begin
         wall_ms = wall_ms + $urandom_range(0, 40000);
      end else begin
         wall_ms = wall_ms + $urandom_range(0, 400000);
      end
      light = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 45) begin
         s = int'(thr_cfg) + $urandom_range(0, 3) - 2;
         if (s < 0) s = 0;
         if (s > 127) s = 127;
         soil = s[6:0];
      end else begin
         soil = 7'($urandom_range(0, 127));
      end
      send_update(wall_ms, light, soil, PREDICT);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && stall_pct != 0 && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pump_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, pump_drive %b",
                                      rsp_pump_drive));
         end else if (rsp_pump_drive !== pump_expected[0]) begin
            report_mismatch($sformatf("pump_drive %b, expected %b",
                                      rsp_pump_drive, pump_expected[0]));
            void'(pump_expected.pop_front());
         end else begin
            void'(pump_expected.pop_front());
         end
      end
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      // default limits: threshold 40, 30 s max, 60 min cooldown, 10 s recheck
      add_update(32'd0, 1'b0, 7'd0, 0);
      add_update(32'd100, 1'b1, 7'd40, 0);
      add_update(32'd200, 1'b1, 7'd39, 1);
      add_update(32'd5000, 1'b1, 7'd100, PREDICT);
      add_update(32'd10200, 1'b1, 7'd39, 1);
      add_update(32'd20200, 1'b1, 7'd40, 0);
      add_update(32'd20300, 1'b1, 7'd0, 0);
      add_update(32'd3620200, 1'b1, 7'd0, 1);
      add_update(32'd3650199, 1'b1, 7'd127, 0);
      add_update(32'd7250199, 1'b1, 7'd0, 1);
      add_update(32'd7260198, 1'b1, 7'd127, PREDICT);
      add_update(32'd7280199, 1'b1, 7'd127, 0);
      add_update(32'd10880199, 1'b1, 7'd5, 1);
      add_update(32'd10880200, 1'b0, 7'd5, 0);
      // timestamp wrap
      add_update(32'hFFFF_F000, 1'b1, 7'd0, 1);
      add_update(32'h0000_1000, 1'b1, 7'd127, 1);
      add_update(32'h0000_1710, 1'b1, 7'd127, 0);
      add_update(32'hFFFF_FFFF, 1'b1, 7'd0, 1);
      add_update(32'hFFFF_FFFF, 1'b0, 7'd127, 0);
      // zero cooldown and zero recheck
      add_csr(REG_MOISTURE_THRESHOLD, 16'd100);
      add_csr(REG_COOLDOWN_MINUTES, 16'd0);
      add_csr(REG_RECHECK_SECONDS, 16'd0);
      add_update(32'd1000, 1'b1, 7'd99, 1);
      add_update(32'd1000, 1'b1, 7'd99, 1);
      add_update(32'd1500, 1'b1, 7'd100, 0);
      add_update(32'd1500, 1'b1, 7'd0, 1);
      add_csr(REG_MAX_PUMP_SECONDS, 16'd0);
      add_update(32'd1500, 1'b1, 7'd0, 0);
      add_update(32'd1600, 1'b1, 7'd127, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            write_limit(stim_rows[i].idx, stim_rows[i].value);
         end else begin
            send_update(stim_rows[i].now, stim_rows[i].light, stim_rows[i].soil,
                        stim_rows[i].want_drive);
         end
      end

      wall_ms = 32'd2000;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_limits(16'd40, 16'd3, 16'd1, 16'd1);
            1: load_limits(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
            2: load_limits(16'd100, 16'd0, 16'd0, 16'hFFFF);
            3: load_limits(16'd60, 16'd5, 16'hFFFF, 16'd2);
            4: load_limits(16'd0, 16'd10, 16'd0, 16'd1);
            6: load_limits(16'd50, 16'hFFFF, 16'd0, 16'd3);
            default: load_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 20)),
                                 16'($urandom_range(0, 3)), 16'($urandom_range(0, 10)));
         endcase
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         repeat (225) random_update();
      end

      req_valid <= 1'b0;
      while (pump_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
